// File: rtl/rvg_pkg.sv
// Package for the regular polygon vertex generator: field widths, register
// indexes, configuration record, pipeline stage map and the CORDIC angle table.
// Depends on nothing; every other file imports it.
package rvg_pkg;

   localparam int SIDE_W      = 7;
   localparam int RADIUS_W    = 15;
   localparam int COORD_W     = 16;
   localparam int ANGLE_W     = 16;
   localparam int COLOUR_W    = 24;
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int MAX_SIDES_DEFAULT = 64;
   localparam int SIDE_MIN          = 3;

   localparam logic [SIDE_W-1:0]   SIDES_RESET  = 7'd3;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd13107;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIDE_COUNT  = 3'd0,
      CSR_RADIUS      = 3'd1,
      CSR_CENTER_X    = 3'd2,
      CSR_CENTER_Y    = 3'd3,
      CSR_DEPTH_Z     = 3'd4,
      CSR_START_ANGLE = 3'd5,
      CSR_COLOUR_RGB  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        [SIDE_W-1:0]   sides;
      logic        [RADIUS_W-1:0] radius;
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic signed [COORD_W-1:0]  depth_z;
      logic        [ANGLE_W-1:0]  start_angle;
      logic        [COLOUR_W-1:0] colour;
   } cfg_type;

   // Angle offset divider: number of stages; DIV_STEPS quotient bits are produced per stage.
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = ANGLE_W / DIV_STAGES;

   // CORDIC datapath.
   localparam int CORDIC_STAGES = 14;
   localparam int CORDIC_W      = 34;
   localparam int Z_W           = 17;
   localparam int OFF_W         = CORDIC_W - 16;
   localparam int PROD_W        = RADIUS_W + 16;
   localparam logic [15:0] CORDIC_GAIN = 16'd39797;
   localparam int CORDIC_DEPTH  = CORDIC_STAGES + 2;

   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
      17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326, 17'sd163,
      17'sd81, 17'sd41, 17'sd20, 17'sd10, 17'sd5, 17'sd3, 17'sd1
   };

   // Stage map: input register, divider, CORDIC, output register.
   localparam int DIV_FIRST    = 1;
   localparam int CORDIC_FIRST = DIV_FIRST + DIV_STAGES;
   localparam int NUM_STAGES   = CORDIC_FIRST + CORDIC_DEPTH + 1;

endpackage

// File: rtl/rvg_if.sv
// Handshake interfaces for the vertex generator: request and response words.
// Depends on rvg_pkg for the field widths.
interface rvg_req_if import rvg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] vertex_index;

   modport source (output valid, output vertex_index, input ready);
   modport sink (input valid, input vertex_index, output ready);
endinterface

interface rvg_rsp_if import rvg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic        [CHAN_W-1:0]  red;
   logic        [CHAN_W-1:0]  green;
   logic        [CHAN_W-1:0]  blue;
   logic                      index_bad;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output red,
                   output green, output blue, output index_bad, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, input red,
                 input green, input blue, input index_bad, output ready);
endinterface

// File: rtl/rvg_csr.sv
// Configuration registers of the vertex generator, with side count clamping.
// Depends on rvg_pkg.
module rvg_csr import rvg_pkg::*; #(
   parameter int MAX_SIDES = MAX_SIDES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   localparam int SIDE_LIMIT = 2**SIDE_W - 1;
   localparam int CAP_INT    = (MAX_SIDES < SIDE_LIMIT) ? MAX_SIDES : SIDE_LIMIT;
   localparam logic [SIDE_W-1:0] SIDE_CAP   = CAP_INT[SIDE_W-1:0];
   localparam logic [SIDE_W-1:0] SIDE_FLOOR = SIDE_MIN[SIDE_W-1:0];

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic [SIDE_W-1:0]  sides_raw;
   logic [SIDE_W-1:0]  sides_clamped;

   assign sides_raw = csr_wdata[SIDE_W-1:0];

   always_comb begin
      priority if (sides_raw < SIDE_FLOOR) begin
         sides_clamped = SIDE_FLOOR;
      end else if (sides_raw > SIDE_CAP) begin
         sides_clamped = SIDE_CAP;
      end else begin
         sides_clamped = sides_raw;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIDE_COUNT:  cfg_in.sides       = sides_clamped;
            CSR_RADIUS:      cfg_in.radius      = csr_wdata[RADIUS_W-1:0];
            CSR_CENTER_X:    cfg_in.center_x    = $signed(csr_wdata[COORD_W-1:0]);
            CSR_CENTER_Y:    cfg_in.center_y    = $signed(csr_wdata[COORD_W-1:0]);
            CSR_DEPTH_Z:     cfg_in.depth_z     = $signed(csr_wdata[COORD_W-1:0]);
            CSR_START_ANGLE: cfg_in.start_angle = csr_wdata[ANGLE_W-1:0];
            CSR_COLOUR_RGB:  cfg_in.colour      = csr_wdata[COLOUR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sides       <= SIDES_RESET;
         cfg_ff.radius      <= RADIUS_RESET;
         cfg_ff.center_x    <= '0;
         cfg_ff.center_y    <= '0;
         cfg_ff.depth_z     <= '0;
         cfg_ff.start_angle <= '0;
         cfg_ff.colour      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/rvg_div.sv
// Pipelined restoring divider for the vertex angle offset,
// round(index * 65536 / sides), DIV_STEPS (four) quotient bits per stage.
// Depends on rvg_pkg.
module rvg_div import rvg_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  logic [INDEX_W-1:0]    idx,
   input  logic [SIDE_W-1:0]     sides,
   output logic [ANGLE_W-1:0]    quot
);

   logic [SIDE_W-1:0]  rem_ff [DIV_STAGES];
   logic [ANGLE_W-1:0] low_ff [DIV_STAGES];
   logic [ANGLE_W-1:0] q_ff   [DIV_STAGES];
   logic [SIDE_W-1:0]  rem_in [DIV_STAGES];
   logic [ANGLE_W-1:0] low_in [DIV_STAGES];
   logic [ANGLE_W-1:0] q_in   [DIV_STAGES];

   // The numerator is index * 65536 + sides / 2; the upper part seeds the
   // remainder and the rounding term is shifted in below it.
   always_comb begin
      logic [SIDE_W-1:0]  r;
      logic [ANGLE_W-1:0] l;
      logic [ANGLE_W-1:0] q;
      logic [SIDE_W:0]    t;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = SIDE_W'(idx);
            l = ANGLE_W'(sides >> 1);
            q = '0;
         end else begin
            r = rem_ff[s-1];
            l = low_ff[s-1];
            q = q_ff[s-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            t = {r, l[ANGLE_W-1]};
            l = {l[ANGLE_W-2:0], 1'b0};
            if (t >= {1'b0, sides}) begin
               r = SIDE_W'(t - {1'b0, sides});
               q = {q[ANGLE_W-2:0], 1'b1};
            end else begin
               r = t[SIDE_W-1:0];
               q = {q[ANGLE_W-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         low_in[s] = l;
         q_in[s]   = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            q_ff[s]   <= q_in[s];
         end
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule

// File: rtl/rvg_cordic.sv
// Pipelined rotation-mode CORDIC: angle setup and radius scaling, one
// micro-rotation per stage, then rounding to signed Q18.0 and quadrant restore.
// Depends on rvg_pkg.
module rvg_cordic import rvg_pkg::*; (
   input  logic                     clock,
   input  logic [CORDIC_DEPTH-1:0]  en,
   input  logic [ANGLE_W-1:0]       offset,
   input  logic [ANGLE_W-1:0]       start_angle,
   input  logic [RADIUS_W-1:0]      radius,
   output logic signed [OFF_W-1:0]  cos_r,
   output logic signed [OFF_W-1:0]  sin_r
);

   localparam logic [ANGLE_W-1:0]  QUARTER = ANGLE_W'(2**(ANGLE_W-2));
   localparam logic [ANGLE_W-1:0]  HALF    = ANGLE_W'(2**(ANGLE_W-1));
   localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = CORDIC_W'(2**15);

   logic signed [CORDIC_W-1:0] x_ff    [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] y_ff    [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]      z_ff    [CORDIC_STAGES+1];
   logic                       flip_ff [CORDIC_STAGES+1];
   logic signed [OFF_W-1:0]    cos_ff;
   logic signed [OFF_W-1:0]    sin_ff;

   logic [ANGLE_W-1:0]         angle;
   logic [ANGLE_W-1:0]         angle_q;
   logic                       flip;
   logic [ANGLE_W-1:0]         folded;
   logic [PROD_W-1:0]          prod;
   logic signed [CORDIC_W-1:0] x_bias;
   logic signed [CORDIC_W-1:0] y_bias;
   logic signed [OFF_W-1:0]    x_round;
   logic signed [OFF_W-1:0]    y_round;

   assign angle   = start_angle + offset;
   assign angle_q = angle + QUARTER;
   assign flip    = angle_q[ANGLE_W-1];
   assign folded  = flip ? angle + HALF : angle;
   assign prod    = PROD_W'(radius) * PROD_W'(CORDIC_GAIN);

   assign x_bias  = x_ff[CORDIC_STAGES] + ROUND_BIAS;
   assign y_bias  = y_ff[CORDIC_STAGES] + ROUND_BIAS;
   assign x_round = $signed(x_bias[CORDIC_W-1:16]);
   assign y_round = $signed(y_bias[CORDIC_W-1:16]);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]    <= $signed(CORDIC_W'(prod));
         y_ff[0]    <= '0;
         z_ff[0]    <= Z_W'($signed(folded));
         flip_ff[0] <= flip;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (en[i+1]) begin
            if (!z_ff[i][Z_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TABLE[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TABLE[i];
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
      if (en[CORDIC_DEPTH-1]) begin
         cos_ff <= flip_ff[CORDIC_STAGES] ? -x_round : x_round;
         sin_ff <= flip_ff[CORDIC_STAGES] ? -y_round : y_round;
      end
   end

   assign cos_r = cos_ff;
   assign sin_r = sin_ff;

endmodule

// File: rtl/regular_polygon_vertex_gen.sv
// Regular polygon vertex generator. Each request word carries a vertex index;
// the response word gives that vertex's position, depth, colour and an
// out-of-range flag. The block takes one word per clock cycle while the response
// side is ready or a stage is empty, and answers every word in order through
// one input register, a 4-stage angle-offset divider, a 16-stage CORDIC
// (setup, 14 rotations, rounding) and an output register. While the response
// side stalls, bubbles close up, so requests are still taken while a stage is empty.
// Configuration writes take effect on the next cycle.
// Depends on rvg_pkg, rvg_if, rvg_csr, rvg_div and rvg_cordic.
module regular_polygon_vertex_gen import rvg_pkg::*; #(
   parameter int MAX_SIDES = MAX_SIDES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   rvg_req_if.sink                req_ch,
   rvg_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SUM_W = OFF_W + 1;
   localparam logic signed [SUM_W-1:0]   SUM_HI = SUM_W'(2**(COORD_W-1) - 1);
   localparam logic signed [SUM_W-1:0]   SUM_LO = SUM_W'(-(2**(COORD_W-1)));
   localparam logic signed [COORD_W-1:0] COORD_HI = COORD_W'(2**(COORD_W-1) - 1);
   localparam logic signed [COORD_W-1:0] COORD_LO = COORD_W'(-(2**(COORD_W-1)));
   localparam logic [CHAN_W-1:0]         CHAN_FULL = '1;

   typedef struct packed {
      logic bad;
      logic last;
   } vtx_flags_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      if (v > SUM_HI) begin
         return COORD_HI;
      end else if (v < SUM_LO) begin
         return COORD_LO;
      end
      return $signed(v[COORD_W-1:0]);
   endfunction

   cfg_type                   cfg;
   logic [NUM_STAGES-1:0]     v_ff;
   logic [NUM_STAGES-1:0]     en;
   logic [INDEX_W-1:0]        idx_ff;
   vtx_flags_type             flags_ff [NUM_STAGES-1];
   vtx_flags_type             flags_in;
   logic [ANGLE_W-1:0]        quot;
   logic signed [OFF_W-1:0]   cos_r;
   logic signed [OFF_W-1:0]   sin_r;
   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;
   vtx_flags_type             out_flags;

   logic signed [COORD_W-1:0] pos_x_ff;
   logic signed [COORD_W-1:0] pos_y_ff;
   logic signed [COORD_W-1:0] pos_z_ff;
   logic [CHAN_W-1:0]         red_ff;
   logic [CHAN_W-1:0]         green_ff;
   logic [CHAN_W-1:0]         blue_ff;
   logic                      bad_ff;

   rvg_csr #(
      .MAX_SIDES(MAX_SIDES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A stage may load when the response side is ready or when it or any stage
   // after it is empty, so that a bubble further on can be closed up.
   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         en[k] = rsp_ch.ready || !(&(v_ff | ~({NUM_STAGES{1'b1}} << k)));
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_ch.valid : v_ff[k-1];
            end
         end
      end
   end

   assign flags_in.bad  = SIDE_W'(req_ch.vertex_index) >= cfg.sides;
   assign flags_in.last = SIDE_W'(req_ch.vertex_index) == cfg.sides - SIDE_W'(1);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         idx_ff      <= req_ch.vertex_index;
         flags_ff[0] <= flags_in;
      end
      for (int k = 1; k < NUM_STAGES-1; k++) begin
         if (en[k]) begin
            flags_ff[k] <= flags_ff[k-1];
         end
      end
   end

   rvg_div u_div (
      .clock (clock),
      .en    (en[CORDIC_FIRST-1:DIV_FIRST]),
      .idx   (idx_ff),
      .sides (cfg.sides),
      .quot  (quot)
   );

   rvg_cordic u_cordic (
      .clock       (clock),
      .en          (en[CORDIC_FIRST+CORDIC_DEPTH-1:CORDIC_FIRST]),
      .offset      (quot),
      .start_angle (cfg.start_angle),
      .radius      (cfg.radius),
      .cos_r       (cos_r),
      .sin_r       (sin_r)
   );

   assign out_flags = flags_ff[NUM_STAGES-2];
   assign sum_x = SUM_W'(cfg.center_x) + SUM_W'(cos_r);
   assign sum_y = SUM_W'(cfg.center_y) + SUM_W'(sin_r);

   always_ff @(posedge clock) begin
      if (en[NUM_STAGES-1]) begin
         pos_z_ff <= cfg.depth_z;
         bad_ff   <= out_flags.bad;
         if (out_flags.bad) begin
            pos_x_ff <= cfg.center_x;
            pos_y_ff <= cfg.center_y;
         end else begin
            pos_x_ff <= sat_coord(sum_x);
            pos_y_ff <= sat_coord(sum_y);
         end
         if (out_flags.last && !out_flags.bad) begin
            red_ff   <= CHAN_FULL;
            green_ff <= CHAN_FULL;
            blue_ff  <= CHAN_FULL;
         end else begin
            red_ff   <= cfg.colour[3*CHAN_W-1:2*CHAN_W];
            green_ff <= cfg.colour[2*CHAN_W-1:CHAN_W];
            blue_ff  <= cfg.colour[CHAN_W-1:0];
         end
      end
   end

   assign rsp_ch.valid     = v_ff[NUM_STAGES-1];
   assign rsp_ch.pos_x     = pos_x_ff;
   assign rsp_ch.pos_y     = pos_y_ff;
   assign rsp_ch.pos_z     = pos_z_ff;
   assign rsp_ch.red       = red_ff;
   assign rsp_ch.green     = green_ff;
   assign rsp_ch.blue      = blue_ff;
   assign rsp_ch.index_bad = bad_ff;

   // A full pipeline with a stalled response side must refuse new words.
   assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while the pipeline is full and stalled");

   // An accepted word occupies the input stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_ff[0])
      else $error("accepted word lost at the input stage");

   // A bubble ahead of the output register leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      !v_ff[NUM_STAGES-2] && en[NUM_STAGES-1] |=> !rsp_ch.valid)
      else $error("response word invented from a bubble");

endmodule
